// ----- rtl/prs_pkg.sv -----
// shared types, codes and defaults of the polynomial root solver
package prs_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] OP_LIN  = 2'd0;
  localparam logic [1:0] OP_QUAD = 2'd1;
  localparam logic [1:0] OP_BIQ  = 2'd2;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ONE  = 3'd1;
  localparam logic [2:0] KIND_TWO  = 3'd2;
  localparam logic [2:0] KIND_ALL  = 3'd5;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ALL,
    CLS_LIN,
    CLS_QUAD
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic biq;
    logic disc_zero;
    logic num_neg;
    logic den_neg;
  } prs_ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROOT_GO,
    B_ROOT_WAIT,
    B_DIV1_GO,
    B_DIV1_WAIT,
    B_DIV2_GO,
    B_DIV2_WAIT,
    B_SPL1_GO,
    B_SPL1_WAIT,
    B_SPL2_GO,
    B_SPL2_WAIT,
    B_FINISH
  } back_state_t;

endpackage

// ----- rtl/prs_front.sv -----
// front end: takes transactions, forms products and discriminant, classifies
module prs_front #(
  parameter int WORD_BITS = prs_pkg::DEF_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] coef_a,
  input  logic signed [WORD_BITS-1:0] coef_b,
  input  logic signed [WORD_BITS-1:0] coef_c,
  input  logic                        q_full,
  input  logic                        q_nearly_full,
  output logic                        push,
  output prs_pkg::prs_ctl_t           ctl,
  output logic [WORD_BITS-1:0]        num_mag,
  output logic [WORD_BITS:0]          den_mag,
  output logic [2*WORD_BITS:0]        disc_mag
);
  import prs_pkg::*;

  localparam int W = WORD_BITS;

  logic           accept;
  logic [W-1:0]   ua, ub, uc, abs_a, abs_b, abs_c;
  logic           s1_valid;
  logic [1:0]     s1_op;
  logic           a_neg, b_neg, c_neg;
  logic [W-1:0]   a_mag, b_mag, c_mag;
  logic [2*W-1:0] bb, ac;
  logic [2*W+2:0] ds;
  logic           a_zero, b_zero, c_zero, disc_neg;

  assign busy   = q_full | (s1_valid & q_nearly_full);
  assign accept = start & ~busy;

  assign ua    = coef_a;
  assign ub    = coef_b;
  assign uc    = coef_c;
  assign abs_a = ua[W-1] ? (~ua + 1'b1) : ua;
  assign abs_b = ub[W-1] ? (~ub + 1'b1) : ub;
  assign abs_c = uc[W-1] ? (~uc + 1'b1) : uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_op <= opcode;
      a_neg <= ua[W-1];
      b_neg <= ub[W-1];
      c_neg <= uc[W-1];
      a_mag <= abs_a;
      b_mag <= abs_b;
      c_mag <= abs_c;
      bb    <= abs_b * abs_b;
      ac    <= abs_a * abs_c;
    end
  end

  // b*b - 4*a*c, exact
  assign ds = (a_neg ^ c_neg) ? ({3'b000, bb} + {1'b0, ac, 2'b00})
                              : ({3'b000, bb} - {1'b0, ac, 2'b00});
  assign disc_neg = ds[2*W+2];
  assign disc_mag = ds[2*W:0];

  assign a_zero = (a_mag == '0);
  assign b_zero = (b_mag == '0);
  assign c_zero = (c_mag == '0);
  assign push   = s1_valid;

  always_comb begin
    ctl.cls       = CLS_NONE;
    ctl.biq       = (s1_op == OP_BIQ);
    ctl.disc_zero = (ds == '0);
    ctl.num_neg   = ~b_neg;
    ctl.den_neg   = a_neg;
    num_mag       = b_mag;
    den_mag       = {1'b0, a_mag};
    case (s1_op)
      OP_LIN: begin
        if (a_zero) begin
          ctl.cls = b_zero ? CLS_ALL : CLS_NONE;
        end else begin
          ctl.cls = CLS_LIN;
        end
      end
      OP_QUAD, OP_BIQ: begin
        if (a_zero) begin
          // falls back to linear b*x + c
          if (b_zero) begin
            ctl.cls = c_zero ? CLS_ALL : CLS_NONE;
          end else begin
            ctl.cls     = CLS_LIN;
            ctl.num_neg = ~c_neg;
            ctl.den_neg = b_neg;
            num_mag     = c_mag;
            den_mag     = {1'b0, b_mag};
          end
        end else begin
          ctl.cls = disc_neg ? CLS_NONE : CLS_QUAD;
          den_mag = {a_mag, 1'b0};
        end
      end
      default: begin
        ctl.cls = CLS_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/prs_queue.sv -----
// short queue of classified transactions between front and back
module prs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full,
  output logic             nearly_full
);
  import prs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign empty       = (count == '0);
  assign full        = (count == CW'(QUEUE_DEPTH));
  assign nearly_full = (count >= CW'(QUEUE_DEPTH - 1));
  assign dout        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> !empty)
    else $error("queue empty after a lone push");

endmodule

// ----- rtl/prs_div.sv -----
// restoring divider, one quotient bit a cycle
module prs_div #(
  parameter int NW = 50,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic          fit;

  assign rem_sh = {rem[DW-1:0], quo[NW-1]};
  assign fit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && !start && (cnt == CW'(1));
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CW'(1)) begin
        running <= 1'b0;
      end
    end
    if (start) begin
      cnt   <= CW'(NW);
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (running) begin
      cnt <= cnt - 1'b1;
      rem <= fit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo <= {quo[NW-2:0], fit};
    end
  end

endmodule

// ----- rtl/prs_sqrt.sv -----
// digit-by-digit integer square root, one root bit a cycle, floored
module prs_sqrt #(
  parameter int IW = 66
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IW-1:0]   rad,
  output logic            done,
  output logic [IW/2-1:0] root
);
  localparam int OW = IW / 2;
  localparam int CW = $clog2(OW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [IW-1:0] rad_r;
  logic [OW+1:0] rem, rem_sh, trial;
  logic          fit;

  assign rem_sh = {rem[OW-1:0], rad_r[IW-1:IW-2]};
  assign trial  = {root, 2'b01};
  assign fit    = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && !start && (cnt == CW'(1));
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == CW'(1)) begin
        running <= 1'b0;
      end
    end
    if (start) begin
      cnt   <= CW'(OW);
      rem   <= '0;
      root  <= '0;
      rad_r <= rad;
    end else if (running) begin
      cnt   <= cnt - 1'b1;
      rad_r <= {rad_r[IW-3:0], 2'b00};
      rem   <= fit ? (rem_sh - trial) : rem_sh;
      root  <= {root[OW-2:0], fit};
    end
  end

endmodule

// ----- rtl/prs_back.sv -----
// back end: sequences square roots and divisions, assembles and saturates roots
module prs_back #(
  parameter int WORD_BITS = prs_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = prs_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        pop,
  input  prs_pkg::prs_ctl_t           ctl,
  input  logic [WORD_BITS-1:0]        num_mag,
  input  logic [WORD_BITS:0]          den_mag,
  input  logic [2*WORD_BITS:0]        disc_mag,
  output logic                        done,
  output logic [2:0]                  solution_kind,
  output logic signed [WORD_BITS-1:0] root_one,
  output logic signed [WORD_BITS-1:0] root_two,
  output logic signed [WORD_BITS-1:0] root_three,
  output logic signed [WORD_BITS-1:0] root_four,
  output logic                        overflow
);
  import prs_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int NUMW   = W + 2 + F;
  localparam int DENW   = W + 1;
  localparam int DSW    = 2 * W + 1;
  localparam int YW     = NUMW + F;
  localparam int SQ_RAW = (DSW > YW) ? DSW : YW;
  localparam int SQ_IN  = SQ_RAW + (SQ_RAW % 2);
  localparam int SQ_OUT = SQ_IN / 2;
  localparam int RW     = (NUMW > SQ_OUT) ? NUMW : SQ_OUT;
  localparam int NS     = W + 3;

  back_state_t state, state_next;

  prs_ctl_t          e_ctl;
  logic [W-1:0]      e_num;
  logic [DENW-1:0]   e_den;
  logic [DSW-1:0]    e_disc;
  logic [W:0]        root_r;
  logic              q1_neg, q2_neg;
  logic [NUMW-1:0]   q1_mag, q2_mag;
  logic [SQ_OUT-1:0] r1, r2;

  logic              sq_start, sq_done, dv_start, dv_done;
  logic [SQ_IN-1:0]  sq_rad;
  logic [SQ_OUT-1:0] sq_root;
  logic [NUMW-1:0]   dv_num, dv_quo;

  logic [NS-1:0]     mbs, n1s, n2s, n1a, n2a;
  logic [NUMW-1:0]   dividend1, dividend2;

  logic [1:0]        s1, s2;
  logic              one_y;
  logic [2:0]        res_kind;
  logic              x_neg [4];
  logic [RW-1:0]     x_mag [4];
  logic [W:0]        x_sat [4];

  prs_sqrt #(.IW(SQ_IN)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  prs_div #(.NW(NUMW), .DW(DENW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (e_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // numerators -b - root and -b + root, root is zero for linear
  assign mbs       = e_ctl.num_neg ? (NS'(0) - NS'(e_num)) : NS'(e_num);
  assign n1s       = mbs - NS'(root_r);
  assign n2s       = mbs + NS'(root_r);
  assign n1a       = n1s[NS-1] ? (NS'(0) - n1s) : n1s;
  assign n2a       = n2s[NS-1] ? (NS'(0) - n2s) : n2s;
  assign dividend1 = {n1a[W+1:0], {F{1'b0}}};
  assign dividend2 = {n2a[W+1:0], {F{1'b0}}};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          case (ctl.cls)
            CLS_LIN:  state_next = B_DIV1_GO;
            CLS_QUAD: state_next = B_ROOT_GO;
            default:  state_next = B_FINISH;
          endcase
        end
      end
      B_ROOT_GO:   state_next = B_ROOT_WAIT;
      B_ROOT_WAIT: if (sq_done) state_next = B_DIV1_GO;
      B_DIV1_GO:   state_next = B_DIV1_WAIT;
      B_DIV1_WAIT: begin
        if (dv_done) begin
          if (e_ctl.cls == CLS_QUAD) begin
            state_next = B_DIV2_GO;
          end else begin
            state_next = e_ctl.biq ? B_SPL1_GO : B_FINISH;
          end
        end
      end
      B_DIV2_GO:   state_next = B_DIV2_WAIT;
      B_DIV2_WAIT: if (dv_done) state_next = e_ctl.biq ? B_SPL1_GO : B_FINISH;
      B_SPL1_GO:   state_next = B_SPL1_WAIT;
      B_SPL1_WAIT: if (sq_done) state_next = one_y ? B_FINISH : B_SPL2_GO;
      B_SPL2_GO:   state_next = B_SPL2_WAIT;
      B_SPL2_WAIT: if (sq_done) state_next = B_FINISH;
      B_FINISH:    state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !q_empty;
    sq_start = (state == B_ROOT_GO) || (state == B_SPL1_GO) || (state == B_SPL2_GO);
    dv_start = (state == B_DIV1_GO) || (state == B_DIV2_GO);
    dv_num   = (state == B_DIV2_GO) ? dividend2 : dividend1;
    case (state)
      B_ROOT_GO: sq_rad = SQ_IN'(e_disc);
      B_SPL1_GO: sq_rad = SQ_IN'({q1_mag, {F{1'b0}}});
      default:   sq_rad = SQ_IN'({q2_mag, {F{1'b0}}});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_FINISH);
    end
    if (pop) begin
      e_ctl  <= ctl;
      e_num  <= num_mag;
      e_den  <= den_mag;
      e_disc <= disc_mag;
      root_r <= '0;
    end
    if (state == B_ROOT_WAIT && sq_done) begin
      root_r <= sq_root[W:0];
    end
    if (state == B_DIV1_WAIT && dv_done) begin
      q1_mag <= dv_quo;
      q1_neg <= (n1s[NS-1] ^ e_ctl.den_neg) && (dv_quo != '0);
    end
    if (state == B_DIV2_WAIT && dv_done) begin
      q2_mag <= dv_quo;
      q2_neg <= (n2s[NS-1] ^ e_ctl.den_neg) && (dv_quo != '0);
    end
    if (state == B_SPL1_WAIT && sq_done) begin
      r1 <= sq_root;
    end
    if (state == B_SPL2_WAIT && sq_done) begin
      r2 <= sq_root;
    end
    if (state == B_FINISH) begin
      solution_kind <= res_kind;
      root_one      <= x_sat[0][W-1:0];
      root_two      <= x_sat[1][W-1:0];
      root_three    <= x_sat[2][W-1:0];
      root_four     <= x_sat[3][W-1:0];
      overflow      <= x_sat[0][W] | x_sat[1][W] | x_sat[2][W] | x_sat[3][W];
    end
  end

  // a single y when the equation in y is linear or the quadratic in y has one root
  assign one_y = (e_ctl.cls == CLS_LIN) || e_ctl.disc_zero;
  assign s1    = q1_neg ? 2'd0 : ((q1_mag == '0) ? 2'd1 : 2'd2);
  assign s2    = q2_neg ? 2'd0 : ((q2_mag == '0) ? 2'd1 : 2'd2);

  always_comb begin
    res_kind = KIND_NONE;
    for (int i = 0; i < 4; i++) begin
      x_neg[i] = 1'b0;
      x_mag[i] = '0;
    end
    case (e_ctl.cls)
      CLS_ALL: res_kind = KIND_ALL;
      CLS_LIN, CLS_QUAD: begin
        if (!e_ctl.biq) begin
          res_kind = one_y ? KIND_ONE : KIND_TWO;
          x_neg[0] = q1_neg;
          x_mag[0] = RW'(q1_mag);
          if (e_ctl.cls == CLS_QUAD) begin
            x_neg[1] = q2_neg;
            x_mag[1] = RW'(q2_mag);
          end
        end else begin
          res_kind = one_y ? {1'b0, s1} : (3'({1'b0, s1}) + 3'({1'b0, s2}));
          if (s1 == 2'd2) begin
            x_neg[0] = 1'b1;
            x_mag[0] = RW'(r1);
            x_mag[1] = RW'(r1);
          end
          // roots of the second y follow those of the first
          if (!one_y && s2 == 2'd2) begin
            case (s1)
              2'd0: begin
                x_neg[0] = 1'b1;
                x_mag[0] = RW'(r2);
                x_mag[1] = RW'(r2);
              end
              2'd1: begin
                x_neg[1] = 1'b1;
                x_mag[1] = RW'(r2);
                x_mag[2] = RW'(r2);
              end
              default: begin
                x_neg[2] = 1'b1;
                x_mag[2] = RW'(r2);
                x_mag[3] = RW'(r2);
              end
            endcase
          end
        end
      end
      default: res_kind = KIND_NONE;
    endcase
  end

  // {saturated flag, word}
  function automatic logic [W:0] sat_root(input logic neg, input logic [RW-1:0] mag);
    logic [RW-1:0] half, half_m1, negv;
    logic [W:0]    res;
    half    = RW'(1) << (W - 1);
    half_m1 = half - RW'(1);
    negv    = RW'(0) - mag;
    if (neg) begin
      res = (mag > half) ? {1'b1, half[W-1:0]} : {1'b0, negv[W-1:0]};
    end else begin
      res = (mag > half_m1) ? {1'b1, half_m1[W-1:0]} : {1'b0, mag[W-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x_sat[i] = sat_root(x_neg[i], x_mag[i]);
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == B_FINISH))
    else $error("result strobe without a finished transaction");
  a_one_unit_start: assert property (@(posedge clk) disable iff (rst)
    !(sq_start && dv_start))
    else $error("square root and divider started together");
  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == B_ROOT_WAIT || state == B_SPL1_WAIT || state == B_SPL2_WAIT))
    else $error("square root finished while not awaited");
  a_empty_kind_zero: assert property (@(posedge clk) disable iff (rst)
    done && (solution_kind == KIND_NONE || solution_kind == KIND_ALL) |->
    root_one == '0 && root_two == '0 && root_three == '0 && root_four == '0 && !overflow)
    else $error("roots reported with no root count");

endmodule

// ----- rtl/polynomial_root_solver.sv -----
// top level of the polynomial root solver: front, queue and back
//
//   port group          dir   handshake              contents
//   command             in    start / busy           opcode, coef_a, coef_b, coef_c
//   result              out   done (one-cycle)       solution_kind, root_one..root_four,
//                                                    overflow
//
// a transaction is taken on a clock edge with start high and busy low; it is registered in
// the product stage and then waits in the two-entry queue, so two go in back to back before
// busy rises. the back takes one at a time on a shared divider of W+F+2 steps and square root
// of S steps (S = half the radicand width, 33 at 32/16): one division for linear, a square
// root of the discriminant and two divisions for quadratic, and one or two split square roots
// more for biquadratic; nothing is divided when there is no root or every x is a root.
// reset is synchronous, rst high; no clearing pass. done cannot be held off by the receiver.
module polynomial_root_solver #(
  parameter int WORD_BITS = prs_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = prs_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] coef_a,
  input  logic signed [WORD_BITS-1:0] coef_b,
  input  logic signed [WORD_BITS-1:0] coef_c,
  output logic                        done,
  output logic [2:0]                  solution_kind,
  output logic signed [WORD_BITS-1:0] root_one,
  output logic signed [WORD_BITS-1:0] root_two,
  output logic signed [WORD_BITS-1:0] root_three,
  output logic signed [WORD_BITS-1:0] root_four,
  output logic                        overflow
);
  import prs_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CB = $bits(prs_ctl_t);
  localparam int QW = CB + W + (W + 1) + (2 * W + 1);

  logic              push, pop, q_empty, q_full, q_nearly_full;
  prs_ctl_t          f_ctl, q_ctl;
  logic [W-1:0]      f_num, q_num;
  logic [W:0]        f_den, q_den;
  logic [2*W:0]      f_disc, q_disc;
  logic [QW-1:0]     q_din, q_dout;

  prs_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .coef_a        (coef_a),
    .coef_b        (coef_b),
    .coef_c        (coef_c),
    .q_full        (q_full),
    .q_nearly_full (q_nearly_full),
    .push          (push),
    .ctl           (f_ctl),
    .num_mag       (f_num),
    .den_mag       (f_den),
    .disc_mag      (f_disc)
  );

  assign q_din = {f_ctl, f_num, f_den, f_disc};

  prs_queue #(.WIDTH(QW)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .din         (q_din),
    .pop         (pop),
    .dout        (q_dout),
    .empty       (q_empty),
    .full        (q_full),
    .nearly_full (q_nearly_full)
  );

  assign {q_ctl, q_num, q_den, q_disc} = q_dout;

  prs_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .pop           (pop),
    .ctl           (q_ctl),
    .num_mag       (q_num),
    .den_mag       (q_den),
    .disc_mag      (q_disc),
    .done          (done),
    .solution_kind (solution_kind),
    .root_one      (root_one),
    .root_two      (root_two),
    .root_three    (root_three),
    .root_four     (root_four),
    .overflow      (overflow)
  );

endmodule
